[sv/column_block_record_parser_core_macros.svh]
// Assertion helpers shared by the parser RTL.
// Each macro samples on the rising edge of clk and is off while rst_n is low.
`ifndef COLUMN_BLOCK_RECORD_PARSER_CORE_MACROS_SVH
`define COLUMN_BLOCK_RECORD_PARSER_CORE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CBRP_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define CBRP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[sv/cbrp_pkg.sv]
`default_nettype none

package cbrp_pkg;

    // Parse phase of the record currently being read, one-hot.
    typedef enum logic [4:0] {
        PH_REP  = 5'b00001,
        PH_DEF  = 5'b00010,
        PH_TYPE = 5'b00100,
        PH_LEN  = 5'b01000,
        PH_DATA = 5'b10000
    } phase_t;

    // Status codes reported with record_last.
    localparam logic [1:0] STAT_OK     = 2'd0;
    localparam logic [1:0] STAT_RUNOUT = 2'd1;
    localparam logic [1:0] STAT_ERR    = 2'd2;

    // Type codes: 0..12 are fixed width, 13..15 carry a length, 16 is null.
    localparam logic [4:0] CODE_NULL   = 5'd16;
    localparam logic [7:0] FIXED_TYPES = 8'd13;
    localparam logic [7:0] CODE_BOOL   = 8'd12;

    // Register index of the level limit.
    localparam logic REG_LEVEL_MAX = 1'b0;
    localparam logic [8:0] LEVEL_MAX_RESET = 9'd256;

    // Value size of a fixed-width type: even codes are 32-bit, odd 64-bit,
    // and the boolean type is a single byte.
    function automatic logic [3:0] fixed_len(input logic [7:0] code);
        logic [3:0] len;
        if (code == CODE_BOOL) begin
            len = 4'd1;
        end
        else if (code[0]) begin
            len = 4'd8;
        end
        else begin
            len = 4'd4;
        end
        return len;
    endfunction

endpackage

`default_nettype wire

[sv/column_block_record_parser_core.sv]
// Column record deframer. One stream byte enters per word on the input
// channel and at most one result word leaves per input word; the parser
// takes a new byte in every cycle while in_ready is high. Each byte is
// decoded combinationally against the parse state registers; its result
// goes to one output register and appears there in the cycle after its
// byte is accepted. in_ready is high whenever the output register is
// empty or being drained in the same cycle. Header and length bytes produce
// no word unless they close the record, hit the buffer end or fail a check.
// After a parse error, bytes are dropped up to and including the next byte
// flagged with buffer_end. The level limit register is at byte address 0 of
// the APB port and should only be written while the parser is idle.
`default_nettype none

`include "column_block_record_parser_core_macros.svh"

module column_block_record_parser_core
    import cbrp_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,

    // Stream input
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [7:0]  data_byte,
    input  wire logic        buffer_end,

    // Result output
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [7:0]       rep_level,
    output logic [7:0]       def_level,
    output logic [4:0]       rec_type,
    output logic [31:0]      rec_len,
    output logic [7:0]       payload_byte,
    output logic             byte_valid,
    output logic             record_last,
    output logic [32:0]      record_bytes,
    output logic [1:0]       status,

    // Configuration port
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    // Configuration register.
    logic [8:0] level_max_reg;

    // Parse state.
    phase_t      phase_reg, phase_next;
    logic [7:0]  rep_reg, rep_next;
    logic [7:0]  def_reg, def_next;
    logic [4:0]  type_reg, type_next;
    logic [31:0] len_reg, len_next;
    logic [31:0] left_reg, left_next;
    logic [32:0] seen_reg, seen_next;
    logic [1:0]  idx_reg, idx_next;
    logic        discard_reg, discard_next;

    // Output register.
    logic        out_valid_reg;
    logic [7:0]  out_rep_reg;
    logic [7:0]  out_def_reg;
    logic [4:0]  out_type_reg;
    logic [31:0] out_len_reg;
    logic [7:0]  out_pay_reg;
    logic        out_bv_reg;
    logic        out_last_reg;
    logic [32:0] out_bytes_reg;
    logic [1:0]  out_stat_reg;

    // Decode results for the current byte.
    logic        emit;
    logic        emit_valid;
    logic        emit_last;
    logic [1:0]  emit_stat;
    logic        in_fire;
    logic        level_err;
    logic [31:0] left_merged;

    // APB access: always ready, the level limit is the only register.
    assign pready = 1'b1;

    always_comb
    begin
        if (paddr[2] == REG_LEVEL_MAX) begin
            prdata = {23'd0, level_max_reg};
        end
        else begin
            prdata = 32'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            level_max_reg <= LEVEL_MAX_RESET;
        end
        else if (psel && penable && pwrite && pready && (paddr[2] == REG_LEVEL_MAX)) begin
            level_max_reg <= pwdata[8:0];
        end
    end

    // Input handshake: a byte is taken whenever the output slot is free or being drained.
    assign in_ready = !out_valid_reg || out_ready;
    assign in_fire  = in_valid && in_ready;

    // Level check against the limit, applied once the type byte arrives.
    assign level_err = ({1'b0, rep_reg} > level_max_reg) ||
                       ({1'b0, def_reg} > level_max_reg);

    // Length byte merged into its little-endian lane.
    always_comb
    begin
        left_merged = left_reg;
        case (idx_reg)
            2'd0:    left_merged[7:0]   = data_byte;
            2'd1:    left_merged[15:8]  = data_byte;
            2'd2:    left_merged[23:16] = data_byte;
            default: left_merged[31:24] = data_byte;
        endcase
    end

    // Byte decode: next parse state and the result word, if any.
    always_comb
    begin
        phase_next   = phase_reg;
        rep_next     = rep_reg;
        def_next     = def_reg;
        type_next    = type_reg;
        len_next     = len_reg;
        left_next    = left_reg;
        seen_next    = seen_reg + 33'd1;
        idx_next     = idx_reg;
        discard_next = discard_reg;
        emit         = 1'b0;
        emit_valid   = 1'b0;
        emit_last    = 1'b0;
        emit_stat    = STAT_OK;

        if (discard_reg) begin
            // Drop bytes until the buffer ends.
            seen_next = seen_reg;
            if (buffer_end) begin
                discard_next = 1'b0;
            end
        end
        else begin
            case (phase_reg)
                PH_REP:
                begin
                    rep_next   = data_byte;
                    def_next   = 8'd0;
                    type_next  = CODE_NULL;
                    len_next   = 32'd0;
                    left_next  = 32'd0;
                    idx_next   = 2'd0;
                    seen_next  = 33'd1;
                    if (buffer_end) begin
                        emit      = 1'b1;
                        emit_last = 1'b1;
                        emit_stat = STAT_RUNOUT;
                    end
                    else begin
                        phase_next = PH_DEF;
                    end
                end
                PH_DEF:
                begin
                    def_next = data_byte;
                    if (buffer_end) begin
                        emit       = 1'b1;
                        emit_last  = 1'b1;
                        emit_stat  = STAT_RUNOUT;
                        phase_next = PH_REP;
                    end
                    else begin
                        phase_next = PH_TYPE;
                    end
                end
                PH_TYPE:
                begin
                    type_next  = (data_byte <= {3'd0, CODE_NULL}) ? data_byte[4:0] : CODE_NULL;
                    phase_next = PH_REP;
                    if (level_err || (data_byte > {3'd0, CODE_NULL})) begin
                        // Bad header: report it and skip to the buffer end.
                        emit         = 1'b1;
                        emit_last    = 1'b1;
                        emit_stat    = STAT_ERR;
                        discard_next = !buffer_end;
                    end
                    else if (data_byte == {3'd0, CODE_NULL}) begin
                        emit      = 1'b1;
                        emit_last = 1'b1;
                    end
                    else begin
                        if (data_byte < FIXED_TYPES) begin
                            len_next   = {28'd0, fixed_len(data_byte)};
                            left_next  = {28'd0, fixed_len(data_byte)};
                            phase_next = PH_DATA;
                        end
                        else begin
                            idx_next   = 2'd0;
                            left_next  = 32'd0;
                            phase_next = PH_LEN;
                        end
                        if (buffer_end) begin
                            emit       = 1'b1;
                            emit_last  = 1'b1;
                            emit_stat  = STAT_RUNOUT;
                            phase_next = PH_REP;
                        end
                    end
                end
                PH_LEN:
                begin
                    left_next = left_merged;
                    if (idx_reg == 2'd3) begin
                        idx_next = 2'd0;
                        len_next = left_merged;
                        if (left_merged == 32'd0) begin
                            // Empty value: the record ends with its length.
                            emit       = 1'b1;
                            emit_last  = 1'b1;
                            phase_next = PH_REP;
                        end
                        else begin
                            phase_next = PH_DATA;
                        end
                    end
                    else begin
                        idx_next = idx_reg + 2'd1;
                    end
                    if (!emit && buffer_end) begin
                        emit       = 1'b1;
                        emit_last  = 1'b1;
                        emit_stat  = STAT_RUNOUT;
                        phase_next = PH_REP;
                    end
                end
                default:
                begin
                    // Value bytes: every one is passed on.
                    left_next  = left_reg - 32'd1;
                    emit       = 1'b1;
                    emit_valid = 1'b1;
                    if (left_next == 32'd0) begin
                        emit_last  = 1'b1;
                        phase_next = PH_REP;
                    end
                    else if (buffer_end) begin
                        emit_last  = 1'b1;
                        emit_stat  = STAT_RUNOUT;
                        phase_next = PH_REP;
                    end
                end
            endcase
        end
    end

    // Parse state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            phase_reg   <= PH_REP;
            rep_reg     <= 8'd0;
            def_reg     <= 8'd0;
            type_reg    <= CODE_NULL;
            len_reg     <= 32'd0;
            left_reg    <= 32'd0;
            seen_reg    <= 33'd0;
            idx_reg     <= 2'd0;
            discard_reg <= 1'b0;
        end
        else if (in_fire) begin
            phase_reg   <= phase_next;
            rep_reg     <= rep_next;
            def_reg     <= def_next;
            type_reg    <= type_next;
            len_reg     <= len_next;
            left_reg    <= left_next;
            seen_reg    <= seen_next;
            idx_reg     <= idx_next;
            discard_reg <= discard_next;
        end
    end

    // Output valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            out_valid_reg <= 1'b0;
        end
        else if (in_fire && emit) begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    // Output word payload.
    always_ff @(posedge clk)
    begin
        if (in_fire && emit) begin
            out_rep_reg   <= rep_next;
            out_def_reg   <= def_next;
            out_type_reg  <= type_next;
            out_len_reg   <= len_next;
            out_pay_reg   <= emit_valid ? data_byte : 8'd0;
            out_bv_reg    <= emit_valid;
            out_last_reg  <= emit_last;
            out_bytes_reg <= emit_last ? seen_next : 33'd0;
            out_stat_reg  <= emit_last ? emit_stat : STAT_OK;
        end
    end

    assign out_valid    = out_valid_reg;
    assign rep_level    = out_rep_reg;
    assign def_level    = out_def_reg;
    assign rec_type     = out_type_reg;
    assign rec_len      = out_len_reg;
    assign payload_byte = out_pay_reg;
    assign byte_valid   = out_bv_reg;
    assign record_last  = out_last_reg;
    assign record_bytes = out_bytes_reg;
    assign status       = out_stat_reg;

    // Checks on the parser's own bookkeeping.
    `CBRP_ASSERT_SAME(a_mid_record_clean, out_valid && !record_last,
        (status == STAT_OK) && (record_bytes == 33'd0), "mid-record word carries end info")
    `CBRP_ASSERT_SAME(a_payload_zero, out_valid && !byte_valid,
        payload_byte == 8'd0, "payload byte set without byte_valid")
    `CBRP_ASSERT_SAME(a_discard_at_header, discard_reg,
        phase_reg == PH_REP, "discarding outside header phase")
    `CBRP_ASSERT_NEXT(a_discard_silent, in_fire && discard_reg && !(out_valid_reg && !out_ready),
        !out_valid_reg, "word produced while discarding")

endmodule

`default_nettype wire

[test/cbrp_record_checker.sv]
// Watches the stream, result and configuration ports of the column record
// deframer, predicts every result word from the accepted stream bytes and
// compares each accepted result word with the oldest prediction.
module cbrp_record_checker
    import cbrp_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,

    input  wire logic        in_valid,
    input  wire logic        in_ready,
    input  wire logic [7:0]  data_byte,
    input  wire logic        buffer_end,

    input  wire logic        out_valid,
    input  wire logic        out_ready,
    input  wire logic [7:0]  rep_level,
    input  wire logic [7:0]  def_level,
    input  wire logic [4:0]  rec_type,
    input  wire logic [31:0] rec_len,
    input  wire logic [7:0]  payload_byte,
    input  wire logic        byte_valid,
    input  wire logic        record_last,
    input  wire logic [32:0] record_bytes,
    input  wire logic [1:0]  status,

    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    input  wire logic        pready,

    output int               mismatches,
    output int               pending,
    output int               words_seen,
    output int               records_closed
);

    localparam logic [2:0] LEVEL_MAX_ADDR = {REG_LEVEL_MAX, 2'b00};

    // One result word, laid out in port order.
    typedef struct packed {
        logic [7:0]  rep;
        logic [7:0]  def;
        logic [4:0]  vtype;
        logic [31:0] vlen;
        logic [7:0]  pay;
        logic        bvalid;
        logic        last;
        logic [32:0] nbytes;
        logic [1:0]  stat;
    } rec_word_t;

    rec_word_t expected_q[$];
    rec_word_t got;
    rec_word_t want;

    // Predicted parser state and its copy of the level limit.
    logic [8:0]  level_cap;
    phase_t      parse_ph;
    logic [7:0]  cur_rep;
    logic [7:0]  cur_def;
    logic [4:0]  cur_type;
    logic [31:0] cur_len;
    logic [31:0] value_left;
    logic [32:0] rec_count;
    logic [1:0]  len_idx;
    logic        dropping;

    int n_bad;
    int n_words;
    int n_recs;

    function automatic string show(input rec_word_t w);
        return $sformatf({"rep=%0d def=%0d type=%0d len=%0d pay=%0d",
                          " bv=%0d last=%0d bytes=%0d st=%0d"},
                         w.rep, w.def, w.vtype, w.vlen, w.pay, w.bvalid, w.last, w.nbytes,
                         w.stat);
    endfunction

    task automatic queue_word(input logic [7:0] pay, input logic bv, input logic last,
                              input logic [1:0] st);
        rec_word_t w;
        w.rep    = cur_rep;
        w.def    = cur_def;
        w.vtype  = cur_type;
        w.vlen   = cur_len;
        w.pay    = bv ? pay : 8'd0;
        w.bvalid = bv;
        w.last   = last;
        w.nbytes = last ? rec_count : 33'd0;
        w.stat   = last ? st : STAT_OK;
        expected_q.push_back(w);
    endtask

    // Close the record with a final word; a parse error that does not land on
    // the buffer end starts dropping bytes.
    task automatic close_record(input logic [7:0] pay, input logic bv, input logic [1:0] st,
                                input logic at_end);
        queue_word(pay, bv, 1'b1, st);
        parse_ph = PH_REP;
        if (st == STAT_ERR && !at_end)
            dropping = 1'b1;
    endtask

    // Advance the predicted parse state by one stream byte.
    task automatic parse_byte(input logic [7:0] b, input logic at_end);
        if (dropping) begin
            if (at_end)
                dropping = 1'b0;
        end
        else begin
            if (parse_ph == PH_REP) begin
                cur_rep    = b;
                cur_def    = 8'd0;
                cur_type   = CODE_NULL;
                cur_len    = 32'd0;
                value_left = 32'd0;
                len_idx    = 2'd0;
                rec_count  = 33'd0;
            end
            rec_count = rec_count + 33'd1;

            case (parse_ph)
                PH_REP: begin
                    if (at_end)
                        close_record(8'd0, 1'b0, STAT_RUNOUT, at_end);
                    else
                        parse_ph = PH_DEF;
                end
                PH_DEF: begin
                    cur_def = b;
                    if (at_end)
                        close_record(8'd0, 1'b0, STAT_RUNOUT, at_end);
                    else
                        parse_ph = PH_TYPE;
                end
                PH_TYPE: begin
                    cur_type = (b <= {3'b000, CODE_NULL}) ? b[4:0] : CODE_NULL;
                    // Levels are checked before the type code.
                    if ({1'b0, cur_rep} > level_cap || {1'b0, cur_def} > level_cap
                            || b > {3'b000, CODE_NULL}) begin
                        close_record(8'd0, 1'b0, STAT_ERR, at_end);
                    end
                    else if (b == {3'b000, CODE_NULL}) begin
                        close_record(8'd0, 1'b0, STAT_OK, at_end);
                    end
                    else begin
                        if (b < FIXED_TYPES) begin
                            cur_len    = (b == CODE_BOOL) ? 32'd1 : (b[0] ? 32'd8 : 32'd4);
                            value_left = cur_len;
                            parse_ph   = PH_DATA;
                        end
                        else begin
                            len_idx    = 2'd0;
                            value_left = 32'd0;
                            parse_ph   = PH_LEN;
                        end
                        if (at_end)
                            close_record(8'd0, 1'b0, STAT_RUNOUT, at_end);
                    end
                end
                PH_LEN: begin
                    // Length arrives least significant byte first.
                    value_left = value_left | ({24'd0, b} << (8 * len_idx));
                    if (len_idx == 2'd3) begin
                        len_idx = 2'd0;
                        cur_len = value_left;
                        if (value_left == 32'd0) begin
                            close_record(8'd0, 1'b0, STAT_OK, at_end);
                        end
                        else begin
                            parse_ph = PH_DATA;
                            if (at_end)
                                close_record(8'd0, 1'b0, STAT_RUNOUT, at_end);
                        end
                    end
                    else begin
                        len_idx = len_idx + 2'd1;
                        if (at_end)
                            close_record(8'd0, 1'b0, STAT_RUNOUT, at_end);
                    end
                end
                default: begin
                    value_left = value_left - 32'd1;
                    if (value_left == 32'd0)
                        close_record(b, 1'b1, STAT_OK, at_end);
                    else if (at_end)
                        close_record(b, 1'b1, STAT_RUNOUT, at_end);
                    else
                        queue_word(b, 1'b1, 1'b0, STAT_OK);
                end
            endcase
        end
    endtask

    // Predict on accepted bytes, then check the accepted result word.
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            level_cap  = LEVEL_MAX_RESET;
            parse_ph   = PH_REP;
            cur_rep    = 8'd0;
            cur_def    = 8'd0;
            cur_type   = CODE_NULL;
            cur_len    = 32'd0;
            value_left = 32'd0;
            rec_count  = 33'd0;
            len_idx    = 2'd0;
            dropping   = 1'b0;
            expected_q.delete();
            n_bad   = 0;
            n_words = 0;
            n_recs  = 0;
            mismatches     <= 0;
            pending        <= 0;
            words_seen     <= 0;
            records_closed <= 0;
        end
        else begin
            if (psel && penable && pwrite && pready && paddr == LEVEL_MAX_ADDR)
                level_cap = pwdata[8:0];

            if (in_valid && in_ready)
                parse_byte(data_byte, buffer_end);

            if (out_valid && out_ready) begin
                got = {rep_level, def_level, rec_type, rec_len, payload_byte,
                       byte_valid, record_last, record_bytes, status};
                n_words++;
                if (record_last)
                    n_recs++;
                if (expected_q.size() == 0) begin
                    n_bad++;
                    if (n_bad <= 10)
                        $display("unexpected result word at %0t: %s", $time, show(got));
                end
                else begin
                    want = expected_q.pop_front();
                    if (got !== want) begin
                        n_bad++;
                        if (n_bad <= 10) begin
                            $display("result word mismatch at %0t", $time);
                            $display("  expected %s", show(want));
                            $display("  actual   %s", show(got));
                        end
                    end
                end
            end

            mismatches     <= n_bad;
            pending        <= expected_q.size();
            words_seen     <= n_words;
            records_closed <= n_recs;
        end
    end

endmodule

[test/tb_column_block_record_parser_core.sv]
// Stimulus and verdict for the column record deframer. Stream bytes are sent
// as buffers of back-to-back records; the checker beside the block predicts
// and compares every result word.
module tb_column_block_record_parser_core;
    import cbrp_pkg::*;

    localparam logic [2:0] LEVEL_MAX_ADDR = {REG_LEVEL_MAX, 2'b00};
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int BYTES_PER_SETTING = 280;
    localparam int NULL_CODE = CODE_NULL;
    localparam int FIRST_VAR_CODE = FIXED_TYPES;
    localparam int LAST_VAR_CODE = CODE_NULL - 1;

    logic        clk;
    logic        rst_n = 1'b0;

    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [7:0]  data_byte = 8'd0;
    logic        buffer_end = 1'b0;

    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [7:0]  rep_level;
    logic [7:0]  def_level;
    logic [4:0]  rec_type;
    logic [31:0] rec_len;
    logic [7:0]  payload_byte;
    logic        byte_valid;
    logic        record_last;
    logic [32:0] record_bytes;
    logic [1:0]  status;

    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = 3'd0;
    logic [31:0] pwdata = 32'd0;
    logic [31:0] prdata;
    logic        pready;

    int mismatches;
    int pending;
    int words_seen;
    int records_closed;

    int bytes_sent = 0;
    int burst_left = 0;
    int settings_used = 0;
    int quiet_cycles = 0;
    int stall_mode = 0;
    int stall_run = 0;
    logic [8:0] level_limit = LEVEL_MAX_RESET;
    logic [7:0] frame_q[$];

    column_block_record_parser_core dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .data_byte    (data_byte),
        .buffer_end   (buffer_end),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .rep_level    (rep_level),
        .def_level    (def_level),
        .rec_type     (rec_type),
        .rec_len      (rec_len),
        .payload_byte (payload_byte),
        .byte_valid   (byte_valid),
        .record_last  (record_last),
        .record_bytes (record_bytes),
        .status       (status),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    cbrp_record_checker record_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .data_byte      (data_byte),
        .buffer_end     (buffer_end),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .rep_level      (rep_level),
        .def_level      (def_level),
        .rec_type       (rec_type),
        .rec_len        (rec_len),
        .payload_byte   (payload_byte),
        .byte_valid     (byte_valid),
        .record_last    (record_last),
        .record_bytes   (record_bytes),
        .status         (status),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .pready         (pready),
        .mismatches     (mismatches),
        .pending        (pending),
        .words_seen     (words_seen),
        .records_closed (records_closed)
    );

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    // The receiver switches between always ready, light and heavy random
    // stalls, and a periodic one-cycle stall.
    always @(posedge clk)
    begin
        if (stall_run == 0) begin
            stall_mode <= $urandom_range(0, 3);
            stall_run  <= $urandom_range(20, 120);
        end
        else begin
            stall_run <= stall_run - 1;
        end
        case (stall_mode)
            0:       out_ready <= 1'b1;
            1:       out_ready <= ($urandom_range(0, 3) != 0);
            2:       out_ready <= ($urandom_range(0, 1) != 0);
            default: out_ready <= (stall_run % 8 != 0);
        endcase
    end

    // Ends the run if no word moves for too long.
    always @(posedge clk)
    begin
        if (rst_n) begin
            if ((in_valid && in_ready) || (out_valid && out_ready) || psel)
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("watchdog expired after %0d idle cycles", quiet_cycles);
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    // Sends one stream word; bursts of random length end in random gaps.
    task automatic send_byte(input logic [7:0] b, input logic at_end);
        int gap;
        data_byte  <= b;
        buffer_end <= at_end;
        in_valid   <= 1'b1;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        bytes_sent++;
        if (burst_left > 0) begin
            burst_left--;
        end
        else begin
            burst_left = $urandom_range(0, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    // Stops sending and waits until every predicted word has come out.
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_level_max(input logic [8:0] v);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= LEVEL_MAX_ADDR;
        pwdata  <= {23'd0, v};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        level_limit = v;
        settings_used++;
    endtask

    function automatic logic [7:0] rand_byte();
        logic [7:0] v;
        v = 8'($urandom_range(0, 255));
        return v;
    endfunction

    // Levels favor the limits of the allowed range.
    function automatic logic [7:0] pick_level(input int top);
        logic [7:0] v;
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
            v = 8'd0;
        else if (r == 1)
            v = 8'(top);
        else
            v = 8'($urandom_range(0, top));
        return v;
    endfunction

    // Appends one record, a broken record or some noise to the frame.
    // A random declared length, sent with at most six value bytes, forces the buffer to end after them.
    task automatic add_record(output logic forced_end);
        int kind;
        int lvl_top;
        int sel;
        int count;
        logic [7:0] code;
        logic [31:0] vlen;
        forced_end = 1'b0;
        lvl_top = (level_limit > 255) ? 255 : level_limit;
        kind = $urandom_range(0, 99);
        if (kind < 5) begin
            repeat ($urandom_range(1, 5)) frame_q.push_back(rand_byte());
        end
        else if (kind < 10 && lvl_top < 255) begin
            // One of the two levels above the limit.
            if ($urandom_range(0, 1) == 0) begin
                frame_q.push_back(8'($urandom_range(lvl_top + 1, 255)));
                frame_q.push_back(rand_byte());
            end
            else begin
                frame_q.push_back(pick_level(lvl_top));
                frame_q.push_back(8'($urandom_range(lvl_top + 1, 255)));
            end
            frame_q.push_back(rand_byte());
        end
        else if (kind < 14) begin
            frame_q.push_back(pick_level(lvl_top));
            frame_q.push_back(pick_level(lvl_top));
            frame_q.push_back(8'($urandom_range(NULL_CODE + 1, 255)));
        end
        else begin
            sel = $urandom_range(0, 99);
            if (sel < 15)
                code = 8'(NULL_CODE);
            else if (sel < 55)
                code = 8'($urandom_range(0, FIRST_VAR_CODE - 1));
            else
                code = 8'($urandom_range(FIRST_VAR_CODE, LAST_VAR_CODE));
            frame_q.push_back(pick_level(lvl_top));
            frame_q.push_back(pick_level(lvl_top));
            frame_q.push_back(code);
            if (code < FIXED_TYPES) begin
                count = (code == CODE_BOOL) ? 1 : (code[0] ? 8 : 4);
                repeat (count) frame_q.push_back(rand_byte());
            end
            else if (code != NULL_CODE) begin
                if ($urandom_range(0, 19) == 0) begin
                    vlen = $urandom;
                    count = $urandom_range(0, 6);
                    forced_end = 1'b1;
                end
                else begin
                    vlen = ($urandom_range(0, 9) == 0) ? $urandom_range(6, 40)
                                                       : $urandom_range(0, 5);
                    count = vlen;
                end
                for (int k = 0; k < 4; k++)
                    frame_q.push_back(vlen[8*k +: 8]);
                repeat (count) frame_q.push_back(rand_byte());
            end
        end
    endtask

    // Sends one buffer of records; some buffers are cut off early.
    task automatic send_buffer();
        int nrec;
        int cut;
        logic forced;
        frame_q.delete();
        forced = 1'b0;
        nrec = $urandom_range(1, 6);
        for (int r = 0; r < nrec && !forced; r++)
            add_record(forced);
        cut = frame_q.size() - 1;
        if (!forced && $urandom_range(0, 9) == 0)
            cut = $urandom_range(0, frame_q.size() - 1);
        for (int i = 0; i <= cut; i++)
            send_byte(frame_q[i], i == cut);
    endtask

    initial
    begin
        logic [8:0] settings[5];
        int goal;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part at the reset level limit: null record with top levels,
        // a boolean, a zero-length string, and a buffer ending in a payload.
        send_byte(8'd255, 1'b0);
        send_byte(8'd255, 1'b0);
        send_byte(8'(NULL_CODE), 1'b0);
        send_byte(8'd0, 1'b0);
        send_byte(8'd0, 1'b0);
        send_byte(CODE_BOOL, 1'b0);
        send_byte(8'hff, 1'b0);
        send_byte(8'd1, 1'b0);
        send_byte(8'd2, 1'b0);
        send_byte(8'(FIRST_VAR_CODE), 1'b0);
        repeat (4) send_byte(8'd0, 1'b0);
        send_byte(8'd0, 1'b0);
        send_byte(8'd0, 1'b0);
        send_byte(8'd1, 1'b0);
        send_byte(8'haa, 1'b1);
        drain();

        // Level error on the buffer end, unknown type followed by dropped
        // bytes, and a buffer that ends on a header byte.
        write_level_max(9'd3);
        send_byte(8'd4, 1'b0);
        send_byte(8'd0, 1'b0);
        send_byte(8'd0, 1'b1);
        send_byte(8'd0, 1'b0);
        send_byte(8'd0, 1'b0);
        send_byte(8'hff, 1'b0);
        send_byte(8'd0, 1'b0);
        send_byte(8'hff, 1'b1);
        send_byte(8'd7, 1'b1);
        drain();

        // Random buffers under several level limit settings.
        settings[0] = 9'd0;
        settings[1] = 9'd255;
        settings[2] = 9'd1;
        settings[3] = 9'($urandom_range(2, 254));
        settings[4] = LEVEL_MAX_RESET;
        for (int s = 0; s < 5; s++) begin
            write_level_max(settings[s]);
            goal = bytes_sent + BYTES_PER_SETTING;
            while (bytes_sent < goal)
                send_buffer();
            drain();
        end

        $display("Sent %0d stream bytes under %0d level limit settings;", bytes_sent,
                 settings_used + 1);
        $display("checked %0d result words closing %0d records.", words_seen, records_closed);
        if (mismatches == 0 && pending == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
